// ----- rtl/fpr_pkg.sv -----
// Shared types, byte codes and reply tables for the framed packet parser and responder.
// Used by the parser, queue, sender and top level; depends on nothing else.
package fpr_pkg;

  // Frame byte codes.
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [7:0] ID_ALIVE   = 8'hF0;
  localparam logic [7:0] CODE_ACK   = 8'h0D;
  localparam logic [7:0] CODE_OTHER = 8'hDD;
  localparam logic [7:0] LEN_ALIVE  = 8'h03;
  localparam logic [7:0] LEN_OTHER  = 8'h02;

  // Seed for the running checksum, excluding the length byte.
  localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  // Checksums of the two fixed replies.
  localparam logic [7:0] CKS_ALIVE = HDR_XOR ^ LEN_ALIVE ^ ID_ALIVE ^ CODE_ACK;
  localparam logic [7:0] CKS_OTHER = HDR_XOR ^ LEN_OTHER ^ CODE_OTHER;

  // Reply byte index and the positions of the checksum byte.
  localparam int unsigned REPLY_IDX_W = 4;
  localparam logic [REPLY_IDX_W-1:0] IDX_LAST_ALIVE = 4'd8;
  localparam logic [REPLY_IDX_W-1:0] IDX_LAST_OTHER = 4'd7;

  // Default depth of the command queue between parser and sender.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_N     = 3'd1,
    PH_E     = 3'd2,
    PH_R     = 3'd3,
    PH_LEN   = 3'd4,
    PH_TOKEN = 3'd5,
    PH_BODY  = 3'd6
  } phase_e;

  // One reply command: which of the two replies to send.
  typedef struct packed {
    logic alive;
  } reply_cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Byte at a given position of a reply frame.
  function automatic logic [7:0] reply_byte(input logic alive,
                                            input logic [REPLY_IDX_W-1:0] idx);
    logic [7:0] b;
    b = CH_U;
    unique case (idx)
      4'd0: b = CH_U;
      4'd1: b = CH_N;
      4'd2: b = CH_E;
      4'd3: b = CH_R;
      4'd4: b = alive ? LEN_ALIVE : LEN_OTHER;
      4'd5: b = CH_COLON;
      4'd6: b = alive ? ID_ALIVE : CODE_OTHER;
      4'd7: b = alive ? CODE_ACK : CKS_OTHER;
      4'd8: b = CKS_ALIVE;
      default: b = CH_U;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/framed_packet_parser_responder_top.sv -----
// Top level of the framed packet parser and responder.
// Instantiates fpr_parser, fpr_queue and fpr_sender; depends on fpr_pkg.
//
// Received bytes are taken at one per cycle whenever the reply queue has
// room; a good frame leaves a command in a queue of QUEUE_DEPTH entries and
// the sender turns each command into a reply of nine bytes (ID F0) or eight
// bytes (any other ID), one per cycle while the receiver is ready, with
// last_byte_o marking the checksum. A waiting reply follows the previous one
// without a gap cycle. The rx side stalls only when the queue is full, which
// is set by the sender's one-byte-per-cycle output and by tx_ready_i.
module framed_packet_parser_responder_top #(
  parameter int unsigned QUEUE_DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       tx_valid_o,
  input  logic       tx_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       last_byte_o
);
  import fpr_pkg::*;

  logic       in_fire;
  logic       push;
  logic       pop;
  reply_cmd_t push_cmd;
  reply_cmd_t head_cmd;
  q_status_t  q_status;

  assign rx_ready_o = !q_status.full;
  assign in_fire    = rx_valid_i && rx_ready_o;

  // Front: frame parser.
  fpr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Command queue.
  fpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // Back: reply sender.
  fpr_sender u_sender (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .status_i    (q_status),
    .pop_o       (pop),
    .tx_valid_o  (tx_valid_o),
    .tx_ready_i  (tx_ready_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

`ifndef SYNTH
  // A command is never offered to a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("reply command pushed into a full queue");

  // The checksum byte is always one of the two fixed reply checksums.
  a_last_cks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && last_byte_o) |-> (tx_byte_o == CKS_ALIVE || tx_byte_o == CKS_OTHER))
    else $error("last reply byte is not a valid checksum");

  // Mid-frame, the sender keeps presenting bytes.
  a_frame_cont : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && tx_ready_i && !last_byte_o) |=> tx_valid_o)
    else $error("reply frame broken off before its checksum");

  // A reply always starts with the first header byte.
  a_frame_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o && tx_ready_i && last_byte_o) |=> (!tx_valid_o || tx_byte_o == CH_U))
    else $error("reply frame does not start with the header");
`endif

endmodule

// ----- rtl/fpr_parser.sv -----
// Front part: parses received bytes and issues a reply command on a good frame.
// Depends on fpr_pkg.
module fpr_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_fire_i,
  input  logic [7:0]          rx_byte_i,
  output logic                push_o,
  output fpr_pkg::reply_cmd_t cmd_o
);
  import fpr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] id_q, id_d;
  logic       seen_q, seen_d;
  logic [7:0] cnt;
  logic [7:0] reply_id;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      xor_q   <= '0;
      id_q    <= '0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
      id_q    <= id_d;
      seen_q  <= seen_d;
    end
  end

  // Next phase, running checksum and reply command.
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    xor_d    = xor_q;
    id_d     = id_q;
    seen_d   = seen_q;
    push_o   = 1'b0;
    cnt      = (left_q == 8'd0) ? 8'd255 : left_q;
    reply_id = seen_q ? id_q : rx_byte_i;
    if (in_fire_i) begin
      unique case (phase_q)
        PH_N:     phase_d = (rx_byte_i == CH_N) ? PH_E : PH_HUNT;
        PH_E:     phase_d = (rx_byte_i == CH_E) ? PH_R : PH_HUNT;
        PH_R:     phase_d = (rx_byte_i == CH_R) ? PH_LEN : PH_HUNT;
        PH_LEN: begin
          left_d  = rx_byte_i;
          phase_d = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (rx_byte_i == CH_COLON) begin
            phase_d = PH_BODY;
            xor_d   = HDR_XOR ^ left_q;
            seen_d  = 1'b0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (cnt > 8'd1) begin
            xor_d  = xor_q ^ rx_byte_i;
            left_d = cnt - 8'd1;
            if (!seen_q) begin
              id_d   = rx_byte_i;
              seen_d = 1'b1;
            end
          end else begin
            left_d  = '0;
            push_o  = (xor_q == rx_byte_i);
            phase_d = PH_HUNT;
          end
        end
        default:  phase_d = PH_HUNT;
      endcase
      // A byte that ends in the hunt phase is examined again as a possible U.
      if (phase_d == PH_HUNT && rx_byte_i == CH_U) begin
        phase_d = PH_N;
        xor_d   = '0;
      end
    end
  end

  assign cmd_o.alive = (reply_id == ID_ALIVE);

endmodule

// ----- rtl/fpr_queue.sv -----
// Short register queue of reply commands between the parser and the sender.
// Depends on fpr_pkg.
module fpr_queue #(
  parameter int unsigned DEPTH = fpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fpr_pkg::reply_cmd_t cmd_i,
  input  logic                pop_i,
  output fpr_pkg::reply_cmd_t cmd_o,
  output fpr_pkg::q_status_t  status_o
);
  import fpr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  reply_cmd_t         mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign cmd_o          = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/fpr_sender.sv -----
// Back part: sends one reply frame per queued command, one byte per cycle
// while tx_ready_i is high. Depends on fpr_pkg.
module fpr_sender (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpr_pkg::reply_cmd_t cmd_i,
  input  fpr_pkg::q_status_t  status_i,
  output logic                pop_o,
  output logic                tx_valid_o,
  input  logic                tx_ready_i,
  output logic [7:0]          tx_byte_o,
  output logic                last_byte_o
);
  import fpr_pkg::*;

  logic                   busy_q;
  logic                   alive_q;
  logic [REPLY_IDX_W-1:0] idx_q;
  logic                   out_fire;

  assign tx_valid_o  = busy_q;
  assign tx_byte_o   = reply_byte(alive_q, idx_q);
  assign last_byte_o = (idx_q == (alive_q ? IDX_LAST_ALIVE : IDX_LAST_OTHER));
  assign out_fire    = busy_q && tx_ready_i;
  // Take the next command when idle or as the current frame's last byte leaves.
  assign pop_o       = !status_i.empty && (!busy_q || (out_fire && last_byte_o));

  // Frame position and command in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      alive_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      busy_q  <= 1'b1;
      alive_q <= cmd_i.alive;
      idx_q   <= '0;
    end else if (out_fire) begin
      if (last_byte_o) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + REPLY_IDX_W'(1);
      end
    end
  end

endmodule
